### hw/rtl/mmu_pkg.sv
// Shared types, constants and helpers for the matrix multiply unit.
// No dependencies; used by mmu_cell and matrix_multiply_unit.
package mmu_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 36;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Per-cycle controls for the cell chain
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic shift;
  } cell_ctrl_t;

  // Zero counts as one, anything above MAX_DIM as MAX_DIM; returns last index
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] c;
    begin
      c = v;
      if (v == '0) c = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) c = DIM_W'(MAX_DIM);
      dim_last = IDX_W'(c - DIM_W'(1));
    end
  endfunction

endpackage

### hw/rtl/mmu_cell.sv
// One multiply-accumulate cell of the result-row chain.
// Depends on mmu_pkg.
module mmu_cell
  import mmu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  input  logic [SUM_W-1:0]        acc_next_i,
  output logic [SUM_W-1:0]        acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         acc_q;
  logic [SUM_W-1:0]         prod_ext;

  assign prod_ext = {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // product stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  // clear, accumulate, or hand the finished sum to the neighbor toward the output
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + prod_ext;
    end else if (ctrl_i.shift) begin
      acc_q <= acc_next_i;
    end
  end

  assign acc_o = acc_q;

`ifndef SYNTH
  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.shift && (ctrl_i.acc_en || ctrl_i.acc_clr)))
    else $error("cell shifted while accumulating");
  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.acc_clr && ctrl_i.acc_en))
    else $error("cell cleared while accumulating");
  a_mul_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.shift |-> !ctrl_i.mul_en)
    else $error("cell multiplied during unload");
`endif

endmodule

### hw/rtl/matrix_multiply_unit.sv
// Matrix multiply unit top level: operand stores, sequencer, cell chain, output register.
// Depends on mmu_pkg and mmu_cell.
//
//  channel | signals                                        | direction
//  in      | in_valid_i, in_stall_o, kind/row/col/value_i   | beats into block
//  out     | out_valid_o, out_stall_i, out_row/col/sum/last | beats out of block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | register writes
//
// Load beats are accepted one per cycle, back to back, while no compute is in progress.
// A compute beat runs MAC work over m inner terms per row, plus n*p output beats
// (n rows, m inner, p columns); one cell per result column, one k term per cycle.
// Reset clears both stores through per-entry valid bits and sets dims to 8.
// Output stall holds the unload; the sequencer frees the input once the last result is unloaded.
module matrix_multiply_unit
  import mmu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [DIM_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [IDX_W-1:0]        row_i,
  input  logic [IDX_W-1:0]        col_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [SUM_W-1:0] out_sum_o,
  output logic                    out_last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] n_last, m_last, p_last;
  logic s1_q, s2_q;
  logic in_acc, load_out, out_free;

  logic [VAL_W-1:0] mem_a [MAX_DIM*MAX_DIM];
  logic [VAL_W-1:0] mem_b [MAX_DIM][MAX_DIM];
  logic [MAX_DIM*MAX_DIM-1:0] vld_a_q;
  logic [MAX_DIM-1:0] vld_b_q [MAX_DIM];
  logic [VAL_W-1:0] rd_a_q;
  logic [VAL_W-1:0] rd_b_q [MAX_DIM];
  logic rd_a_vld_q;
  logic [MAX_DIM-1:0] rd_b_vld_q;

  logic signed [VAL_W-1:0] a_op;
  logic [SUM_W-1:0] acc [MAX_DIM+1];
  cell_ctrl_t ctrl;

  assign n_last = dim_last(rows_a_q);
  assign m_last = dim_last(inner_dim_q);
  assign p_last = dim_last(cols_b_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign load_out   = (state_q == ST_OUT) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_W'(MAX_DIM);
      inner_dim_q <= DIM_W'(MAX_DIM);
      cols_b_q    <= DIM_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // store valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      for (int r = 0; r < MAX_DIM; r++) vld_b_q[r] <= '0;
    end else if (in_acc) begin
      if (kind_i == KIND_LOAD_A) vld_a_q[{row_i, col_i}] <= 1'b1;
      if (kind_i == KIND_LOAD_B) vld_b_q[row_i][col_i] <= 1'b1;
    end
  end

  // store writes
  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == KIND_LOAD_A) mem_a[{row_i, col_i}] <= value_i;
    if (in_acc && kind_i == KIND_LOAD_B) mem_b[row_i][col_i] <= value_i;
  end

  // store reads: A element (i,k) and whole B row k
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAC) begin
      rd_a_q     <= mem_a[{i_q, k_q}];
      rd_a_vld_q <= vld_a_q[{i_q, k_q}];
      rd_b_q     <= mem_b[k_q];
      rd_b_vld_q <= vld_b_q[k_q];
    end
  end

  // pipeline tags: read stage and product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= (state_q == ST_MAC);
      s2_q <= s1_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && kind_i == KIND_COMPUTE) begin
          i_d = '0;
          k_d = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_q == m_last) begin
          k_d = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_q && !s2_q) begin
          j_d = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (j_q == p_last) begin
            j_d = '0;
            if (i_q == n_last) begin
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + IDX_W'(1);
              state_d = ST_MAC;
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  // cell chain controls
  always_comb begin
    ctrl.mul_en  = s1_q;
    ctrl.acc_en  = s2_q;
    ctrl.acc_clr = (state_q == ST_MAC) && (k_q == '0);
    ctrl.shift   = load_out;
  end

  assign a_op = rd_a_vld_q ? rd_a_q : '0;
  assign acc[MAX_DIM] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    logic signed [VAL_W-1:0] b_op;
    assign b_op = rd_b_vld_q[c] ? rd_b_q[c] : '0;
    mmu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .a_i        (a_op),
      .b_i        (b_op),
      .acc_next_i (acc[c+1]),
      .acc_o      (acc[c])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_o  <= i_q;
      out_col_o  <= j_q;
      out_sum_o  <= acc[0];
      out_last_o <= (i_q == n_last) && (j_q == p_last);
    end
  end

`ifndef SYNTH
  a_s2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q |-> $past(s1_q))
    else $error("product stage without read stage");
  a_out_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (!s1_q && !s2_q))
    else $error("unload while MAC pipeline busy");
  a_compute_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_COMPUTE) |=> (state_q == ST_MAC))
    else $error("compute beat did not start MAC");
`endif

endmodule
